>>> rtl/bqse_pkg.sv
// ============================================================================
// Biquadratic shape evaluator package
// Fixed-point widths, node tables and shared types for the Q2 shape evaluator.
// ============================================================================
package bqse_pkg;

    // Fractional bits of coordinates and results.
    localparam int FRAC_BITS = 16;

    // Port field widths.
    localparam int COORD_W = 18;
    localparam int VAL_W   = 18;
    localparam int GRAD_W  = 19;
    localparam int NODE_W  = 4;

    // Internal widths, sized for any 18-bit coordinate at 16 fractional bits.
    // Twice a 1D polynomial at scale S^2 lies within -3*2^33 .. 3*2^33.
    localparam int MUL_W  = 36;
    localparam int PMAG_W = 35;
    // Twice a 1D derivative at scale S lies within -2^19 .. 2^19.
    localparam int DER_W  = 21;
    localparam int DMAG_W = 20;
    // Polynomial magnitudes are split in two halves for the products.
    localparam int SPLIT  = 18;
    localparam int PHI_W  = PMAG_W - SPLIT;

    localparam int VAL_SHIFT  = 3 * FRAC_BITS + 2;
    localparam int GRAD_SHIFT = 2 * FRAC_BITS + 2;
    localparam int VSUM_W     = 70;
    localparam int GSUM_W     = 55;
    localparam int VMAG_W     = VSUM_W - VAL_SHIFT;
    localparam int GMAG_W     = GSUM_W - GRAD_SHIFT;

    localparam logic [VSUM_W-1:0] VAL_HALF  = VSUM_W'(1) << (VAL_SHIFT - 1);
    localparam logic [GSUM_W-1:0] GRAD_HALF = GSUM_W'(1) << (GRAD_SHIFT - 1);
    localparam logic [VMAG_W-1:0] VAL_LIM   = VMAG_W'(1) << FRAC_BITS;
    localparam logic [GMAG_W-1:0] GRAD_LIM  = GMAG_W'(1) << (FRAC_BITS + 1);

    typedef logic [NODE_W-1:0] node_idx_t;
    localparam node_idx_t NODE_LAST = node_idx_t'(8);

    // Which 1D quadratic a node uses along one axis.
    typedef enum logic [1:0] {
        SEL_MINUS = 2'd0,
        SEL_ZERO  = 2'd1,
        SEL_PLUS  = 2'd2
    } poly_sel_t;

    // Sign-magnitude terms of one axis, handed to the product stages.
    typedef struct packed {
        logic [PMAG_W-1:0] pmag;
        logic              pneg;
        logic [DMAG_W-1:0] dmag;
        logic              dneg;
    } axis_terms_t;

    // Node order: corners, edge midpoints, center.
    function automatic poly_sel_t ksi_sel(input node_idx_t node);
        poly_sel_t sel;
        unique case (node)
            4'd0, 4'd3, 4'd7: sel = SEL_MINUS;
            4'd1, 4'd2, 4'd5: sel = SEL_PLUS;
            default:          sel = SEL_ZERO;
        endcase
        return sel;
    endfunction

    function automatic poly_sel_t eta_sel(input node_idx_t node);
        poly_sel_t sel;
        unique case (node)
            4'd0, 4'd1, 4'd4: sel = SEL_MINUS;
            4'd2, 4'd3, 4'd6: sel = SEL_PLUS;
            default:          sel = SEL_ZERO;
        endcase
        return sel;
    endfunction

endpackage

>>> rtl/bqse_axis_poly.sv
// ============================================================================
// Axis polynomial stages
// Two pipeline stages that form twice a 1D quadratic and its derivative for
// one coordinate, and hand them on in sign-magnitude form.
// ============================================================================
module bqse_axis_poly (
    input  logic                                 aclk,
    input  logic                                 advance,
    input  logic signed [bqse_pkg::COORD_W-1:0]  coord,
    input  bqse_pkg::poly_sel_t                  sel,
    output bqse_pkg::axis_terms_t                terms
);
    import bqse_pkg::*;

    localparam logic signed [COORD_W:0] ONE_C = (COORD_W + 1)'(2 ** FRAC_BITS);
    localparam logic signed [MUL_W:0]   ONE_SQ =
        (MUL_W + 1)'(64'(1) << (2 * FRAC_BITS));
    localparam logic signed [DER_W-1:0] ONE_D = DER_W'(2 ** FRAC_BITS);

    // Stage one: x * (x + c).
    logic signed [COORD_W:0]     xe;
    logic signed [COORD_W:0]     xc;
    logic signed [MUL_W:0]       prod;
    logic signed [MUL_W-1:0]     mx_reg;
    logic signed [COORD_W-1:0]   x_reg;
    poly_sel_t                   sel_reg;

    assign xe = {coord[COORD_W-1], coord};

    always_comb begin
        unique case (sel)
            SEL_MINUS: xc = xe - ONE_C;
            SEL_PLUS:  xc = xe + ONE_C;
            default:   xc = xe;
        endcase
    end

    assign prod = xe * xc;

    always_ff @(posedge aclk) begin
        if (advance) begin
            mx_reg  <= prod[MUL_W-1:0];
            x_reg   <= coord;
            sel_reg <= sel;
        end
    end

    // Stage two: finish the polynomial and the derivative, take magnitudes.
    logic signed [MUL_W:0]   mx_ext;
    logic signed [MUL_W:0]   p_full;
    logic signed [MUL_W-1:0] p;
    logic signed [MUL_W-1:0] p_abs;
    logic signed [DER_W-1:0] xd;
    logic signed [DER_W-1:0] d;
    logic signed [DER_W-1:0] d_abs;
    axis_terms_t             terms_next;

    assign mx_ext = {mx_reg[MUL_W-1], mx_reg};
    assign xd     = DER_W'(x_reg);

    always_comb begin
        unique case (sel_reg)
            SEL_MINUS: begin
                p_full = mx_ext;
                d      = (xd <<< 1) - ONE_D;
            end
            SEL_PLUS: begin
                p_full = mx_ext;
                d      = (xd <<< 1) + ONE_D;
            end
            default: begin
                // Center polynomial: 2 * (S^2 - x^2), slope -4x.
                p_full = (ONE_SQ - mx_ext) <<< 1;
                d      = -(xd <<< 2);
            end
        endcase
    end

    assign p     = p_full[MUL_W-1:0];
    assign p_abs = p[MUL_W-1] ? -p : p;
    assign d_abs = d[DER_W-1] ? -d : d;

    assign terms_next.pmag = p_abs[PMAG_W-1:0];
    assign terms_next.pneg = p[MUL_W-1];
    assign terms_next.dmag = d_abs[DMAG_W-1:0];
    assign terms_next.dneg = d[DER_W-1];

    always_ff @(posedge aclk) begin
        if (advance) begin
            terms <= terms_next;
        end
    end

endmodule

>>> rtl/biquadratic_quad_shape_eval.sv
// ============================================================================
// Biquadratic quadrilateral shape evaluator
// Evaluates the nine Q2 Lagrange shape functions and their gradients at one
// reference point, streaming one node result per cycle.
// ============================================================================
// Each request on the slave side carries one reference point (ksi, eta) in
// signed fixed point with 16 fractional bits. The block answers with nine
// results, nodes 0 to 8 in order (corners, edge midpoints, center), one per
// cycle; m_tlast marks node 8. Each result holds the shape value, saturated
// to +-1.0, and both partial derivatives, saturated to +-2.0, all rounded to
// nearest with ties away from zero. The node sequencer issues one node per
// cycle while the output is not stalled, into a pipeline of axis polynomial,
// partial product, summation and output registers. The next point is
// accepted in the cycle that issues node 8 of the current one, so results
// flow without gaps. Backpressure on m_tready freezes the whole pipeline, so
// no result is lost or repeated.
module biquadratic_quad_shape_eval (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: ksi_coord [17:0], eta_coord [35:18], zeros above.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // m_tdata: node_index [3:0], shape_value [21:4], grad_ksi [40:22],
    // grad_eta [59:41], zeros above. m_tlast is last_node.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic        m_tlast
);
    import bqse_pkg::*;

    // The whole pipeline moves together whenever the output register can
    // take a new result.
    logic advance;
    logic take;

    assign advance  = !m_tvalid || m_tready;

    // ---------------------------------------------------------------- issue
    // The point register holds the current point while its nine nodes are
    // issued, one per cycle while the pipeline advances.
    logic                      pt_valid_reg;
    node_idx_t                 cnt_reg;
    logic signed [COORD_W-1:0] ksi_reg;
    logic signed [COORD_W-1:0] eta_reg;

    assign s_tready = advance && (!pt_valid_reg || cnt_reg == NODE_LAST);
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (take) begin
            pt_valid_reg <= 1'b1;
            cnt_reg      <= '0;
        end else if (advance && pt_valid_reg) begin
            if (cnt_reg == NODE_LAST) begin
                pt_valid_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + node_idx_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ksi_reg <= s_tdata[COORD_W-1:0];
            eta_reg <= s_tdata[2*COORD_W-1:COORD_W];
        end
    end

    // ----------------------------------------------------- axis polynomials
    // Two stages per axis: the square term, then polynomial and slope in
    // sign-magnitude form.
    axis_terms_t kt;
    axis_terms_t et;

    bqse_axis_poly u_ksi_poly (
        .aclk    (aclk),
        .advance (advance),
        .coord   (ksi_reg),
        .sel     (ksi_sel(cnt_reg)),
        .terms   (kt)
    );

    bqse_axis_poly u_eta_poly (
        .aclk    (aclk),
        .advance (advance),
        .coord   (eta_reg),
        .sel     (eta_sel(cnt_reg)),
        .terms   (et)
    );

    // Valid bits and node numbers travel beside the data.
    logic      v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    node_idx_t node1_reg, node2_reg, node3_reg, node4_reg, node_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= pt_valid_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            node1_reg    <= cnt_reg;
            node2_reg    <= node1_reg;
            node3_reg    <= node2_reg;
            node4_reg    <= node3_reg;
            node_out_reg <= node4_reg;
        end
    end

    // ------------------------------------------------------ partial products
    // The value needs the full product of two 35-bit magnitudes, so it is
    // built from four half-width products. Each gradient splits only the
    // polynomial factor.
    logic [2*PHI_W-1:0]          vhh_reg;
    logic [PHI_W+SPLIT-1:0]      vhl_reg, vlh_reg;
    logic [2*SPLIT-1:0]          vll_reg;
    logic [DMAG_W+PHI_W-1:0]     gkh_reg, geh_reg;
    logic [DMAG_W+SPLIT-1:0]     gkl_reg, gel_reg;
    logic                        vneg3_reg, gkneg3_reg, geneg3_reg;

    logic [PHI_W-1:0] kp_hi, ep_hi;
    logic [SPLIT-1:0] kp_lo, ep_lo;

    assign kp_hi = kt.pmag[PMAG_W-1:SPLIT];
    assign kp_lo = kt.pmag[SPLIT-1:0];
    assign ep_hi = et.pmag[PMAG_W-1:SPLIT];
    assign ep_lo = et.pmag[SPLIT-1:0];

    always_ff @(posedge aclk) begin
        if (advance) begin
            vhh_reg    <= kp_hi * ep_hi;
            vhl_reg    <= kp_hi * ep_lo;
            vlh_reg    <= kp_lo * ep_hi;
            vll_reg    <= kp_lo * ep_lo;
            gkh_reg    <= kt.dmag * ep_hi;
            gkl_reg    <= kt.dmag * ep_lo;
            geh_reg    <= et.dmag * kp_hi;
            gel_reg    <= et.dmag * kp_lo;
            vneg3_reg  <= kt.pneg ^ et.pneg;
            gkneg3_reg <= kt.dneg ^ et.pneg;
            geneg3_reg <= kt.pneg ^ et.dneg;
        end
    end

    // ------------------------------------------------------------ summation
    // Partial products are summed with half an output LSB added for
    // rounding of the magnitude.
    logic [VSUM_W-1:0] val_sum_next, val_sum_reg;
    logic [GSUM_W-1:0] gk_sum_next, gk_sum_reg;
    logic [GSUM_W-1:0] ge_sum_next, ge_sum_reg;
    logic              vneg4_reg, gkneg4_reg, geneg4_reg;

    assign val_sum_next = (VSUM_W'(vhh_reg) << (2 * SPLIT))
                        + ((VSUM_W'(vhl_reg) + VSUM_W'(vlh_reg)) << SPLIT)
                        + VSUM_W'(vll_reg) + VAL_HALF;
    assign gk_sum_next  = (GSUM_W'(gkh_reg) << SPLIT) + GSUM_W'(gkl_reg) + GRAD_HALF;
    assign ge_sum_next  = (GSUM_W'(geh_reg) << SPLIT) + GSUM_W'(gel_reg) + GRAD_HALF;

    always_ff @(posedge aclk) begin
        if (advance) begin
            val_sum_reg <= val_sum_next;
            gk_sum_reg  <= gk_sum_next;
            ge_sum_reg  <= ge_sum_next;
            vneg4_reg   <= vneg3_reg;
            gkneg4_reg  <= gkneg3_reg;
            geneg4_reg  <= geneg3_reg;
        end
    end

    // ---------------------------------------------- scale, saturate, output
    logic [VMAG_W-1:0]        vmag;
    logic [GMAG_W-1:0]        gkmag, gemag;
    logic [VAL_W-1:0]         vclip;
    logic [GRAD_W-1:0]        gkclip, geclip;
    logic signed [VAL_W-1:0]  val_next, val_out_reg;
    logic signed [GRAD_W-1:0] gk_next, gk_out_reg;
    logic signed [GRAD_W-1:0] ge_next, ge_out_reg;

    assign vmag  = val_sum_reg[VSUM_W-1:VAL_SHIFT];
    assign gkmag = gk_sum_reg[GSUM_W-1:GRAD_SHIFT];
    assign gemag = ge_sum_reg[GSUM_W-1:GRAD_SHIFT];

    assign vclip  = (vmag  > VAL_LIM)  ? VAL_W'(VAL_LIM)   : vmag[VAL_W-1:0];
    assign gkclip = (gkmag > GRAD_LIM) ? GRAD_W'(GRAD_LIM) : gkmag[GRAD_W-1:0];
    assign geclip = (gemag > GRAD_LIM) ? GRAD_W'(GRAD_LIM) : gemag[GRAD_W-1:0];

    assign val_next = vneg4_reg  ? -$signed(vclip)  : $signed(vclip);
    assign gk_next  = gkneg4_reg ? -$signed(gkclip) : $signed(gkclip);
    assign ge_next  = geneg4_reg ? -$signed(geclip) : $signed(geclip);

    always_ff @(posedge aclk) begin
        if (advance) begin
            val_out_reg <= val_next;
            gk_out_reg  <= gk_next;
            ge_out_reg  <= ge_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = (node_out_reg == NODE_LAST);
    assign m_tdata  = {4'b0, ge_out_reg, gk_out_reg, val_out_reg, node_out_reg};

endmodule

>>> rtl/bqse_checker.sv
// ============================================================================
// Shape evaluator port checker
// Watches the ports of the shape evaluator and flags broken sequencing.
// ============================================================================
module bqse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    // A held result must not change while it waits.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // The last flag goes with node 8 and nothing else.
    a_last_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[3:0] == 4'd8)))
        else $error("last flag does not match node 8");

    // A point closes the input as soon as it is taken.
    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input reopened right after a point was taken");

    // Shape values stay within +-1.0.
    a_val_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[21:4]) <= 18'sd65536)
                  && ($signed(m_tdata[21:4]) >= -18'sd65536))
        else $error("shape value out of range");

endmodule

bind biquadratic_quad_shape_eval bqse_checker u_bqse_checker (.*);
